// File: design/risk_grid_disk_dilation_top_assert.svh
// Assertion macros for the risk grid disk dilation block.
`ifndef RISK_GRID_DISK_DILATION_TOP_ASSERT_SVH
`define RISK_GRID_DISK_DILATION_TOP_ASSERT_SVH

// Clocked assertion on clk_i, quiet while rst_ni is low.
`define RGDD_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("rgdd assertion failed");

// Same-cycle implication built on the macro above.
`define RGDD_ASSERT_IMP(lbl, ante, cons) \
  `RGDD_ASSERT(lbl, (ante) |-> (cons))

`endif

// File: design/rgdd_pkg.sv
// Shared types and constants for the risk grid disk dilation block.
`default_nettype none
package rgdd_pkg;

  localparam int DEF_MAX_WIDTH  = 256;
  localparam int DEF_MAX_HEIGHT = 256;
  localparam int DEF_MAX_RADIUS = 15;
  localparam int DEF_VALUE_BITS = 16;

  localparam int CFG_W   = 9;
  localparam int COORD_W = 8;
  localparam int FUNC_W  = 3;
  localparam int IO_VAL_W = 16;
  localparam int STAT_W  = 2;
  localparam int RAD_IN_W = 4;
  localparam int IDX_W   = 2;

  localparam logic [FUNC_W-1:0] FUNC_SET     = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_SETMAX  = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_GET     = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_INFLATE = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_FILL    = 3'd4;

  localparam logic [STAT_W-1:0] ST_DONE    = 2'd0;
  localparam logic [STAT_W-1:0] ST_OUTSIDE = 2'd1;
  localparam logic [STAT_W-1:0] ST_SKIP    = 2'd2;

  localparam logic [IDX_W-1:0] REG_WIDTH  = 2'd0;
  localparam logic [IDX_W-1:0] REG_HEIGHT = 2'd1;
  localparam logic [IDX_W-1:0] REG_RADIUS = 2'd2;

  // One neighbor tap of the dilation scan.
  typedef struct packed {
    logic               hit;    // inside grid and inside disk
    logic               first;  // first tap of a cell
    logic               last;   // last tap of a cell
    logic [COORD_W-1:0] cx;
    logic [COORD_W-1:0] cy;
  } tap_t;

endpackage
`default_nettype wire

// File: design/rgdd_addr_unit.sv
// Shared registered address unit: col * height + row.
`default_nettype none
module rgdd_addr_unit
  import rgdd_pkg::*;
#(
  parameter int AW = 16
) (
  input  wire logic               clk_i,
  input  wire logic [COORD_W-1:0] col_i,
  input  wire logic [COORD_W-1:0] row_i,
  input  wire logic [CFG_W-1:0]   height_i,
  output logic      [AW-1:0]      addr_o
);

  localparam int PW = COORD_W + CFG_W + 1;

  logic [PW-1:0] sum;
  logic [AW-1:0] addr_q;

  assign sum = PW'(col_i) * PW'(height_i) + PW'(row_i);

  always_ff @(posedge clk_i) begin
    addr_q <= AW'(sum);
  end

  assign addr_o = addr_q;

endmodule
`default_nettype wire

// File: design/rgdd_scan.sv
// Dilation scan walker: cells in address order, disk taps per cell.
`default_nettype none
module rgdd_scan
  import rgdd_pkg::*;
#(
  parameter int RW = 4
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [CFG_W-1:0] width_i,
  input  wire logic [CFG_W-1:0] height_i,
  input  wire logic [RW-1:0]    radius_i,
  output tap_t                  tap_o,
  output logic                  tap_valid_o,
  output logic                  done_o
);

  localparam int DW = RW + 1;
  localparam int SW = 10;
  localparam int QW = 2 * DW + 2;

  logic               run_q;
  logic [COORD_W-1:0] x_q, y_q;
  logic [DW-1:0]      u_q, v_q;
  logic [DW-1:0]      twor;
  logic [SW-1:0]      xs, ys, r_s;
  logic               in_x, in_y, in_disk;
  logic signed [DW:0] du, dv;
  logic signed [QW-1:0] du_w, dv_w;
  logic [QW-1:0]      su, sv, rw, rr;
  logic               end_v, end_u, end_y, end_x;

  assign twor = {radius_i, 1'b0};
  assign r_s  = SW'(radius_i);
  assign xs   = SW'(x_q) + SW'(u_q);
  assign ys   = SW'(y_q) + SW'(v_q);
  assign in_x = (xs >= r_s) && ((xs - r_s) < SW'(width_i));
  assign in_y = (ys >= r_s) && ((ys - r_s) < SW'(height_i));

  assign du   = $signed({1'b0, u_q}) - $signed({2'b00, radius_i});
  assign dv   = $signed({1'b0, v_q}) - $signed({2'b00, radius_i});
  assign du_w = du;
  assign dv_w = dv;
  assign su   = $unsigned(du_w * du_w);
  assign sv   = $unsigned(dv_w * dv_w);
  assign rw   = QW'(radius_i);
  assign rr   = rw * rw;
  assign in_disk = (su + sv) <= rr;

  assign end_v = (v_q == twor);
  assign end_u = (u_q == twor);
  assign end_y = ({1'b0, y_q} == (height_i - 9'd1));
  assign end_x = ({1'b0, x_q} == (width_i - 9'd1));

  assign tap_o.hit   = in_x && in_y && in_disk;
  assign tap_o.first = (u_q == '0) && (v_q == '0);
  assign tap_o.last  = end_u && end_v;
  assign tap_o.cx    = COORD_W'(xs - r_s);
  assign tap_o.cy    = COORD_W'(ys - r_s);
  assign tap_valid_o = run_q;
  assign done_o      = run_q && end_v && end_u && end_y && end_x;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 1'b0;
      x_q   <= '0;
      y_q   <= '0;
      u_q   <= '0;
      v_q   <= '0;
    end else if (start_i) begin
      run_q <= 1'b1;
      x_q   <= '0;
      y_q   <= '0;
      u_q   <= '0;
      v_q   <= '0;
    end else if (run_q) begin
      if (!end_v) begin
        v_q <= v_q + 1'b1;
      end else begin
        v_q <= '0;
        if (!end_u) begin
          u_q <= u_q + 1'b1;
        end else begin
          u_q <= '0;
          if (!end_y) begin
            y_q <= y_q + 1'b1;
          end else begin
            y_q <= '0;
            if (!end_x) begin
              x_q <= x_q + 1'b1;
            end else begin
              run_q <= 1'b0;
            end
          end
        end
      end
    end
  end

endmodule
`default_nettype wire

// File: design/risk_grid_disk_dilation_top.sv
// Top level of the risk grid disk dilation block: sequencer, stores, config.
// Risk grid with grayscale disk dilation. One transaction runs at a time; the
// input stalls until its result is loaded into the output register. After reset
// the store is cleared by a sweep over all MAX_WIDTH*MAX_HEIGHT entries (65536
// at the defaults), during which no transaction is taken. Set, set-max and get
// step from accept through address multiply, memory read, update and result
// load, then back to idle. An index outside the grid or a skipped inflate goes
// straight to the result load. Fill writes one store entry per cycle over all
// MAX_WIDTH*MAX_HEIGHT entries. Inflate is bounded by the single risk store
// read port, one disk tap per cycle: the tap scan visits every tap of the
// (2r+1)^2 square of each of the W*H cells, including those outside the disk,
// and the scratch store is then copied back into the risk store.
// A stalled result register holds the block in its result state until it drains.
`default_nettype none
module risk_grid_disk_dilation_top
  import rgdd_pkg::*;
#(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
  parameter int MAX_RADIUS = DEF_MAX_RADIUS,
  parameter int VALUE_BITS = DEF_VALUE_BITS
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  // configuration writes
  input  wire logic                cfg_we_i,
  input  wire logic [IDX_W-1:0]    cfg_index_i,
  input  wire logic [CFG_W-1:0]    cfg_data_i,
  // request channel
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire logic [FUNC_W-1:0]   func_i,
  input  wire logic [COORD_W-1:0]  cell_x_i,
  input  wire logic [COORD_W-1:0]  cell_y_i,
  input  wire logic [IO_VAL_W-1:0] write_value_i,
  // result channel
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output logic [IO_VAL_W-1:0]      read_value_o,
  output logic [STAT_W-1:0]        status_o
);

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = AW + 1;
  localparam int RW    = $clog2(MAX_RADIUS + 1);

  // One-hot sequencer states.
  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_FILL  = 9'b000000010,
    S_ADDR  = 9'b000000100,
    S_READ  = 9'b000001000,
    S_RMW   = 9'b000010000,
    S_SCAN  = 9'b000100000,
    S_DRAIN = 9'b001000000,
    S_COPY  = 9'b010000000,
    S_DONE  = 9'b100000000
  } state_e;

  state_e state_q;

  // Config registers and their clamped views.
  logic [CFG_W-1:0]    cfg_w_q, cfg_h_q;
  logic [RAD_IN_W-1:0] cfg_r_q;
  logic [CFG_W-1:0]    w_eff, h_eff;
  logic [RW-1:0]       r_eff;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_w_q <= 9'd256;
      cfg_h_q <= 9'd256;
      cfg_r_q <= 4'd1;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_WIDTH:  cfg_w_q <= cfg_data_i;
        REG_HEIGHT: cfg_h_q <= cfg_data_i;
        REG_RADIUS: cfg_r_q <= cfg_data_i[RAD_IN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (cfg_w_q == '0)                 w_eff = 9'd1;
    else if (32'(cfg_w_q) > MAX_WIDTH) w_eff = 9'(MAX_WIDTH);
    else                               w_eff = cfg_w_q;
    if (cfg_h_q == '0)                  h_eff = 9'd1;
    else if (32'(cfg_h_q) > MAX_HEIGHT) h_eff = 9'(MAX_HEIGHT);
    else                                h_eff = cfg_h_q;
    if (32'(cfg_r_q) > MAX_RADIUS) r_eff = RW'(MAX_RADIUS);
    else                           r_eff = RW'(cfg_r_q);
  end

  // Transaction registers.
  logic [FUNC_W-1:0]     func_q;
  logic [COORD_W-1:0]    x_q, y_q;
  logic [VALUE_BITS-1:0] val_q, fill_val_q;
  logic [IO_VAL_W-1:0]   res_rd_q;
  logic [STAT_W-1:0]     res_st_q;
  logic                  clearing_q;
  logic [AW-1:0]         fill_cnt_q;
  logic                  out_valid_q;
  logic [IO_VAL_W-1:0]   out_rd_q;
  logic [STAT_W-1:0]     out_st_q;

  logic accept;
  logic outside;
  logic scan_mode;
  logic out_load;

  assign accept    = in_valid_i && (state_q == S_IDLE);
  assign outside   = ({1'b0, cell_x_i} >= w_eff) || ({1'b0, cell_y_i} >= h_eff);
  assign scan_mode = (state_q == S_SCAN) || (state_q == S_DRAIN);
  // Result register takes the finished transaction when empty or draining.
  assign out_load  = (state_q == S_DONE) && (!out_valid_q || !out_stall_i);

  // Scan walker and three-deep tap pipeline: addr, read, accumulate.
  tap_t tap_g, tap_a_q, tap_b_q, tap_c_q;
  logic tap_gv, walk_done;
  logic va_q, vb_q, vc_q;
  logic walk_start;

  assign walk_start = accept && (func_i == FUNC_INFLATE) && (r_eff != '0);

  rgdd_scan #(.RW(RW)) u_scan (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (walk_start),
    .width_i    (w_eff),
    .height_i   (h_eff),
    .radius_i   (r_eff),
    .tap_o      (tap_g),
    .tap_valid_o(tap_gv),
    .done_o     (walk_done)
  );

  logic [AW-1:0] addr_u;

  rgdd_addr_unit #(.AW(AW)) u_addr (
    .clk_i   (clk_i),
    .col_i   (scan_mode ? tap_a_q.cx : x_q),
    .row_i   (scan_mode ? tap_a_q.cy : y_q),
    .height_i(h_eff),
    .addr_o  (addr_u)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
    end else begin
      va_q <= tap_gv;
      vb_q <= va_q;
      vc_q <= vb_q;
    end
  end

  always_ff @(posedge clk_i) begin
    tap_a_q <= tap_g;
    tap_b_q <= tap_a_q;
    tap_c_q <= tap_b_q;
  end

  // Memories.
  logic [VALUE_BITS-1:0] risk_mem    [DEPTH];
  logic [VALUE_BITS-1:0] scratch_mem [DEPTH];
  logic [VALUE_BITS-1:0] risk_rd_q, scr_rd_q;
  logic                  risk_we;
  logic [AW-1:0]         risk_wa;
  logic [VALUE_BITS-1:0] risk_wd;

  // Running max over the taps of one cell.
  logic [VALUE_BITS-1:0] best_q, cand, acc;
  logic [CW-1:0]         wcell_q;
  logic [CW-1:0]         cp_q;
  logic                  cpv_q;
  logic [AW-1:0]         cpa_q;

  assign cand = tap_c_q.hit ? risk_rd_q : '0;
  assign acc  = (tap_c_q.first || (cand > best_q)) ? cand : best_q;

  always_ff @(posedge clk_i) begin
    if (vc_q) best_q <= acc;
  end

  always_comb begin
    risk_we = 1'b0;
    risk_wa = addr_u;
    risk_wd = val_q;
    case (state_q)
      S_FILL: begin
        risk_we = 1'b1;
        risk_wa = fill_cnt_q;
        risk_wd = fill_val_q;
      end
      S_RMW: begin
        risk_we = (func_q != FUNC_GET);
        risk_wd = ((func_q == FUNC_SET) || (val_q > risk_rd_q)) ? val_q : risk_rd_q;
      end
      S_COPY: begin
        risk_we = cpv_q;
        risk_wa = cpa_q;
        risk_wd = scr_rd_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (risk_we) risk_mem[risk_wa] <= risk_wd;
    risk_rd_q <= risk_mem[addr_u];
  end

  always_ff @(posedge clk_i) begin
    if (vc_q && tap_c_q.last) scratch_mem[wcell_q[AW-1:0]] <= acc;
    scr_rd_q <= scratch_mem[cp_q[AW-1:0]];
  end

  // Sequencer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_FILL;
      clearing_q  <= 1'b1;
      fill_cnt_q  <= '0;
      fill_val_q  <= '0;
      func_q      <= FUNC_SET;
      x_q         <= '0;
      y_q         <= '0;
      val_q       <= '0;
      res_rd_q    <= '0;
      res_st_q    <= ST_DONE;
      wcell_q     <= '0;
      cp_q        <= '0;
      cpv_q       <= 1'b0;
      cpa_q       <= '0;
      out_valid_q <= 1'b0;
      out_rd_q    <= '0;
      out_st_q    <= ST_DONE;
    end else begin
      if (out_load) out_valid_q <= 1'b1;
      else if (out_valid_q && !out_stall_i) out_valid_q <= 1'b0;
      if (vc_q && tap_c_q.last) wcell_q <= wcell_q + 1'b1;

      case (state_q)
        S_IDLE: begin
          if (accept) begin
            func_q   <= func_i;
            x_q      <= cell_x_i;
            y_q      <= cell_y_i;
            val_q    <= VALUE_BITS'(write_value_i);
            res_rd_q <= '0;
            res_st_q <= ST_DONE;
            case (func_i) inside
              FUNC_SET, FUNC_SETMAX, FUNC_GET: begin
                if (outside) begin
                  res_st_q <= ST_OUTSIDE;
                  state_q  <= S_DONE;
                end else begin
                  state_q <= S_ADDR;
                end
              end
              FUNC_INFLATE: begin
                if (r_eff == '0) begin
                  res_st_q <= ST_SKIP;
                  state_q  <= S_DONE;
                end else begin
                  wcell_q <= '0;
                  state_q <= S_SCAN;
                end
              end
              FUNC_FILL: begin
                fill_val_q <= VALUE_BITS'(write_value_i);
                fill_cnt_q <= '0;
                clearing_q <= 1'b0;
                state_q    <= S_FILL;
              end
              default: state_q <= S_DONE;
            endcase
          end
        end
        S_FILL: begin
          fill_cnt_q <= fill_cnt_q + 1'b1;
          if (fill_cnt_q == AW'(DEPTH - 1)) begin
            state_q <= clearing_q ? S_IDLE : S_DONE;
          end
        end
        S_ADDR: state_q <= S_READ;
        S_READ: state_q <= S_RMW;
        S_RMW: begin
          if (func_q == FUNC_GET) res_rd_q <= IO_VAL_W'(risk_rd_q);
          state_q <= S_DONE;
        end
        S_SCAN: begin
          if (walk_done) state_q <= S_DRAIN;
        end
        S_DRAIN: begin
          if (!tap_gv && !va_q && !vb_q && !vc_q) begin
            cp_q    <= '0;
            cpv_q   <= 1'b0;
            state_q <= S_COPY;
          end
        end
        S_COPY: begin
          cpv_q <= (cp_q != wcell_q);
          cpa_q <= cp_q[AW-1:0];
          if (cp_q != wcell_q) cp_q <= cp_q + 1'b1;
          if ((cp_q == wcell_q) && !cpv_q) state_q <= S_DONE;
        end
        S_DONE: begin
          if (out_load) begin
            out_rd_q <= res_rd_q;
            out_st_q <= res_st_q;
            state_q  <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_stall_o   = (state_q != S_IDLE);
  assign out_valid_o  = out_valid_q;
  assign read_value_o = out_rd_q;
  assign status_o     = out_st_q;

endmodule
`default_nettype wire

// File: design/rgdd_checker.sv
// Port-level assertion checker for the risk grid disk dilation top level.
`default_nettype none
`include "risk_grid_disk_dilation_top_assert.svh"
module rgdd_checker
  import rgdd_pkg::*;
(
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                in_valid_i,
  input wire logic                in_stall_o,
  input wire logic                out_valid_o,
  input wire logic                out_stall_i,
  input wire logic [IO_VAL_W-1:0] read_value_o,
  input wire logic [STAT_W-1:0]   status_o
);

  // A held result is not dropped.
  `RGDD_ASSERT(a_out_hold, out_valid_o && out_stall_i |=> out_valid_o)
  // Every transaction moves the sequencer out of idle on accept, so the input stalls after accept.
  `RGDD_ASSERT(a_busy_after_accept, in_valid_i && !in_stall_o |=> in_stall_o)
  // Only the three defined status codes ever appear.
  `RGDD_ASSERT_IMP(a_status_code, out_valid_o,
                   status_o == ST_DONE || status_o == ST_OUTSIDE || status_o == ST_SKIP)
  // A nonzero read value only comes with a completed get.
  `RGDD_ASSERT_IMP(a_read_status, out_valid_o && (read_value_o != '0), status_o == ST_DONE)

endmodule

bind risk_grid_disk_dilation_top rgdd_checker u_rgdd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .read_value_o(read_value_o),
  .status_o    (status_o)
);
`default_nettype wire
